FILE: design/lkvc_pkg.sv
// ============================================================================
// lkvc_pkg
// Shared sizes, request codes and controller/datapath interface types for
// the LRU key-value cache.
// ============================================================================
`default_nettype none

package lkvc_pkg;

  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CAP_WIDTH   = 5;
  localparam int IDX_W       = $clog2(ENTRIES);
  localparam int RANK_W      = IDX_W;
  localparam int CNT_W       = $clog2(ENTRIES + 1);

  localparam logic [CAP_WIDTH-1:0] CAP_RESET = CAP_WIDTH'(16);

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic load_req;
    logic lookup;
    logic update;
  } cmd_t;

  typedef struct packed {
    logic is_get;
  } stat_t;

endpackage

`default_nettype wire

FILE: design/lru_key_value_cache_core.sv
// ============================================================================
// lru_key_value_cache_core
// Fully associative 16-entry key-value cache with least-recently-used
// replacement.
// ============================================================================
// After acceptance each request passes a lookup step, the parallel key
// compare across all entries, then an update step, the recency rank update
// and store write; a new request is taken in the update cycle, so a request
// is accepted while the last one finishes. Only a get returns a word, held in
// an output register, and a get stalls in its update cycle while that
// register is still full. Capacity may only be written while no request is
// in flight; values 0 and above 16 act as 1 and 16.
`default_nettype none

module lru_key_value_cache_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // [15:0] key, [47:16] value
  input  wire logic        s_tuser,   // req_type: 0 get, 1 put
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // [31:0] read_value
  output logic             m_tuser,   // hit
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  cfg_data   // capacity
);

  lkvc_pkg::cmd_t  cmd;
  lkvc_pkg::stat_t stat;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  lkvc_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .in_req_type (s_tuser),
    .in_key      (s_tdata[15:0]),
    .in_value    (s_tdata[47:16]),
    .out_hit     (m_tuser),
    .out_value   (m_tdata)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted during lookup");

  a_miss_all_ones: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '1))
    else $error("miss word not all ones");

  a_word_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.update && stat.is_get))
    else $error("output word without a get update");

  a_stages_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.lookup && cmd.update))
    else $error("lookup and update in one cycle");

endmodule

`default_nettype wire

FILE: design/lkvc_ctrl.sv
// ============================================================================
// lkvc_ctrl
// Request sequencer: accept, lookup, update; owns the input and output
// handshakes.
// ============================================================================
`default_nettype none

module lkvc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output lkvc_pkg::cmd_t     cmd,
  input  wire lkvc_pkg::stat_t stat
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOOK = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       out_free;
  logic       upd_done;

  assign out_free = !m_tvalid || m_tready;
  assign upd_done = (state == ST_UPD) && (!stat.is_get || out_free);
  assign s_tready = (state == ST_IDLE) || upd_done;

  assign cmd.load_req = s_tvalid && s_tready;
  assign cmd.lookup   = (state == ST_LOOK);
  assign cmd.update   = upd_done;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_LOOK;
      end
      ST_LOOK: state_next = ST_UPD;
      ST_UPD: begin
        if (upd_done) state_next = s_tvalid ? ST_LOOK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (upd_done && stat.is_get) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/lkvc_datapath.sv
// ============================================================================
// lkvc_datapath
// Key/value stores, parallel key match, recency ranks and result register.
// ============================================================================
`default_nettype none

module lkvc_datapath (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire lkvc_pkg::cmd_t                        cmd,
  output lkvc_pkg::stat_t                            stat,
  input  wire logic                                  cfg_we,
  input  wire logic [lkvc_pkg::CAP_WIDTH-1:0]        cfg_data,
  input  wire logic                                  in_req_type,
  input  wire logic [lkvc_pkg::KEY_WIDTH-1:0]        in_key,
  input  wire logic [lkvc_pkg::VALUE_WIDTH-1:0]      in_value,
  output logic                                       out_hit,
  output logic [lkvc_pkg::VALUE_WIDTH-1:0]           out_value
);

  logic [lkvc_pkg::KEY_WIDTH-1:0]   key_store   [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::VALUE_WIDTH-1:0] value_store [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::RANK_W-1:0]      rank        [lkvc_pkg::ENTRIES];
  logic [lkvc_pkg::ENTRIES-1:0]     valid;
  logic [lkvc_pkg::CNT_W-1:0]       live_count;
  logic [lkvc_pkg::CAP_WIDTH-1:0]   capacity;

  logic                             req_type;
  logic [lkvc_pkg::KEY_WIDTH-1:0]   req_key;
  logic [lkvc_pkg::VALUE_WIDTH-1:0] req_value;

  logic                             hit;
  logic                             fill;
  logic [lkvc_pkg::IDX_W-1:0]       tgt;
  logic [lkvc_pkg::CNT_W-1:0]       thr;

  logic [lkvc_pkg::ENTRIES-1:0]     match;
  logic                             hit_next;
  logic                             fill_next;
  logic [lkvc_pkg::IDX_W-1:0]       hit_idx;
  logic [lkvc_pkg::IDX_W-1:0]       free_idx;
  logic [lkvc_pkg::IDX_W-1:0]       old_idx;
  logic [lkvc_pkg::IDX_W-1:0]       tgt_next;
  logic [lkvc_pkg::CNT_W-1:0]       thr_next;
  logic [lkvc_pkg::CNT_W-1:0]       live_m1;
  logic [lkvc_pkg::CNT_W-1:0]       cap_eff;
  logic                             touch;

  assign stat.is_get = (req_type == lkvc_pkg::REQ_GET);
  assign live_m1     = live_count - lkvc_pkg::CNT_W'(1);
  assign touch       = cmd.update && ((req_type == lkvc_pkg::REQ_PUT) || hit);

  always_comb begin
    if (capacity == '0) begin
      cap_eff = lkvc_pkg::CNT_W'(1);
    end else if (int'(capacity) > lkvc_pkg::ENTRIES) begin
      cap_eff = lkvc_pkg::CNT_W'(lkvc_pkg::ENTRIES);
    end else begin
      cap_eff = lkvc_pkg::CNT_W'(capacity);
    end
  end

  // lowest-numbered entry wins in each search
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    old_idx  = '0;
    for (int i = lkvc_pkg::ENTRIES - 1; i >= 0; i--) begin
      match[i] = valid[i] && (key_store[i] == req_key);
      if (match[i]) hit_idx = lkvc_pkg::IDX_W'(i);
      if (!valid[i]) free_idx = lkvc_pkg::IDX_W'(i);
      if (valid[i] && (lkvc_pkg::CNT_W'(rank[i]) == live_m1)) old_idx = lkvc_pkg::IDX_W'(i);
    end
    hit_next  = |match;
    fill_next = 1'b0;
    if (hit_next) begin
      tgt_next = hit_idx;
      thr_next = lkvc_pkg::CNT_W'(rank[hit_idx]);
    end else if (live_count < cap_eff) begin
      tgt_next  = free_idx;
      thr_next  = live_count;
      fill_next = 1'b1;
    end else begin
      tgt_next = old_idx;
      thr_next = live_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_type  <= in_req_type;
      req_key   <= in_key;
      req_value <= in_value;
    end
    if (cmd.lookup) begin
      hit  <= hit_next;
      fill <= fill_next;
      tgt  <= tgt_next;
      thr  <= thr_next;
    end
    if (cmd.update && (req_type == lkvc_pkg::REQ_PUT)) begin
      value_store[tgt] <= req_value;
      if (!hit) key_store[tgt] <= req_key;
    end
    if (cmd.update && (req_type == lkvc_pkg::REQ_GET)) begin
      out_hit   <= hit;
      out_value <= hit ? value_store[tgt] : '1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= lkvc_pkg::CAP_RESET;
      valid      <= '0;
      live_count <= '0;
      for (int i = 0; i < lkvc_pkg::ENTRIES; i++) rank[i] <= '0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      if (touch) begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
          if (lkvc_pkg::IDX_W'(i) == tgt) begin
            rank[i] <= '0;
          end else if (valid[i] && (lkvc_pkg::CNT_W'(rank[i]) < thr)) begin
            rank[i] <= rank[i] + lkvc_pkg::RANK_W'(1);
          end
        end
        valid[tgt] <= 1'b1;
        if (fill) live_count <= live_count + lkvc_pkg::CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire
